// ----- hdl/mts_pkg.sv -----
// Package for the min-tracking stack: operation and status codes, result beat
// layout, controller states and the entry decode helpers.
// No dependencies.
`default_nettype none

package mts_pkg;

    localparam int DEFAULT_STACK_DEPTH = 1024;
    localparam int DATA_W              = 32;
    localparam int ENTRY_W             = 34;
    localparam int MODE_W              = 2;
    localparam int STATUS_W            = 2;
    localparam int OUT_TDATA_W         = 104;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     is_empty;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] popped_value;
    } t_result;

    // Entry below the minimum is an encoded one: the real top is the minimum.
    function automatic logic signed [DATA_W-1:0] decode_top(
        input logic signed [ENTRY_W-1:0] entry,
        input logic signed [DATA_W-1:0]  minimum
    );
        logic signed [ENTRY_W-1:0] min_x;
        min_x = ENTRY_W'(minimum);
        decode_top = (entry < min_x) ? minimum : entry[DATA_W-1:0];
    endfunction

    function automatic logic signed [ENTRY_W-1:0] sext_entry(
        input logic signed [DATA_W-1:0] v
    );
        sext_entry = ENTRY_W'(v);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/min_tracking_stack_core.sv -----
// Min-tracking stack top level: controller, top-entry and minimum registers.
// Depends on mts_pkg and mts_ram.
//
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: mode[1:0]; tdata: push_value[31:0]
// m_axis    out  tdata: popped[31:0] top[63:32] min[95:64] empty[96] status[98:97]
//
// Push, query, refused push, pop on empty and pop of the last entry: result registered from S_IDLE.
// Pop leaving one or more entries: waits in S_POP for the RAM read of the new top, taking no input.
// The top entry lives in a register; the RAM holds the entries below it.
// Synchronous active-low reset empties the stack; RAM contents are not cleared.
// A result waiting on m_axis holds off the next input beat unless it is taken.
`default_nettype none

module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [DATA_W-1:0]      i_s_tdata,  // push_value[31:0]
    input  wire logic [MODE_W-1:0]      i_s_tuser,  // mode[1:0]
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata   // popped, top, min, is_empty, status
);

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(STACK_DEPTH);
    localparam logic [FILL_W-1:0] ONE_COUNT  = FILL_W'(1);
    localparam logic [FILL_W-1:0] TWO_COUNT  = FILL_W'(2);
    localparam logic signed [DATA_W-1:0] NONE_VALUE = -DATA_W'(1);

    t_state                    r_state, n_state;
    logic [FILL_W-1:0]         r_fill, n_fill;
    logic signed [DATA_W-1:0]  r_min, n_min;
    logic signed [ENTRY_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0]  r_pop_value, n_pop_value;
    logic                      r_out_valid, n_out_valid;
    t_result                   r_out, n_out;

    logic                      s_accept;
    logic                      s_load;
    logic [MODE_W-1:0]         s_mode;
    logic signed [DATA_W-1:0]  s_value;
    logic                      s_new_min;
    logic signed [ENTRY_W-1:0] s_min_x;
    logic signed [DATA_W-1:0]  s_popped;
    logic signed [DATA_W-1:0]  s_restored;
    logic [FILL_W-1:0]         s_fill_m1;
    logic [FILL_W-1:0]         s_fill_m2;
    t_result                   s_current;

    logic                      s_ram_we;
    logic [ENTRY_W-1:0]        s_ram_rdata;

    assign s_mode     = i_s_tuser;
    assign s_value    = i_s_tdata;
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_min_x    = sext_entry(r_min);
    assign s_new_min  = (r_fill == '0) || (s_value < r_min);
    assign s_popped   = (r_top > s_min_x) ? r_top[DATA_W-1:0] : r_min;
    assign s_restored = (r_top > s_min_x) ? r_min
                                          : ({r_min[DATA_W-2:0], 1'b0} - r_top[DATA_W-1:0]);
    assign s_fill_m1  = r_fill - ONE_COUNT;
    assign s_fill_m2  = r_fill - TWO_COUNT;
    assign s_ram_we   = (r_state == S_IDLE) && s_accept && (s_mode == MODE_PUSH)
                        && (r_fill != FULL_COUNT) && (r_fill != '0);

    always_comb begin
        s_current.popped_value = NONE_VALUE;
        s_current.status       = STATUS_OK;
        if (r_fill == '0) begin
            s_current.top_value = NONE_VALUE;
            s_current.min_value = NONE_VALUE;
            s_current.is_empty  = 1'b1;
        end else begin
            s_current.top_value = decode_top(r_top, r_min);
            s_current.min_value = r_min;
            s_current.is_empty  = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_min       = r_min;
        n_top       = r_top;
        n_pop_value = r_pop_value;
        n_out       = r_out;
        s_load      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (s_mode)
                        MODE_PUSH: begin
                            s_load = 1'b1;
                            n_out  = s_current;
                            if (r_fill == FULL_COUNT) begin
                                n_out.status = STATUS_OVERFLOW;
                            end else begin
                                n_fill = r_fill + ONE_COUNT;
                                if (s_new_min) begin
                                    n_min = s_value;
                                end
                                if (s_new_min && (r_fill != '0)) begin
                                    n_top = {s_value[DATA_W-1], s_value, 1'b0} - s_min_x;
                                end else begin
                                    n_top = sext_entry(s_value);
                                end
                                n_out.top_value = s_value;
                                n_out.min_value = s_new_min ? s_value : r_min;
                                n_out.is_empty  = 1'b0;
                            end
                        end
                        MODE_POP: begin
                            if (r_fill == '0) begin
                                s_load       = 1'b1;
                                n_out        = s_current;
                                n_out.status = STATUS_UNDERFLOW;
                            end else begin
                                n_fill = s_fill_m1;
                                n_min  = s_restored;
                                if (r_fill == ONE_COUNT) begin
                                    s_load             = 1'b1;
                                    n_out.popped_value = s_popped;
                                    n_out.top_value    = NONE_VALUE;
                                    n_out.min_value    = NONE_VALUE;
                                    n_out.is_empty     = 1'b1;
                                    n_out.status       = STATUS_OK;
                                end else begin
                                    n_pop_value = s_popped;
                                    n_state     = S_POP;
                                end
                            end
                        end
                        default: begin
                            s_load = 1'b1;
                            n_out  = s_current;
                        end
                    endcase
                end
            end
            S_POP: begin
                s_load             = 1'b1;
                n_top              = s_ram_rdata;
                n_out.popped_value = r_pop_value;
                n_out.top_value    = decode_top(s_ram_rdata, r_min);
                n_out.min_value    = r_min;
                n_out.is_empty     = 1'b0;
                n_out.status       = STATUS_OK;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !i_m_tready) || s_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_pop_value <= n_pop_value;
        if (s_load) begin
            r_out <= n_out;
        end
    end

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (s_ram_we),
        .i_waddr (s_fill_m1[ADDR_W-1:0]),
        .i_wdata (r_top),
        .i_raddr (s_fill_m2[ADDR_W-1:0]),
        .o_rdata (s_ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_COUNT)
        else $error("fill count beyond stack depth");

    a_pop_wait_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> !r_out_valid)
        else $error("result pending while top refill in flight");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.is_empty) |->
            (r_out.top_value == NONE_VALUE) && (r_out.min_value == NONE_VALUE))
        else $error("empty result carries a top or minimum");

endmodule

`default_nettype wire

// ----- bench/tb_min_tracking_stack_core.sv -----
// Self-checking bench for min_tracking_stack_core: pushes, pops and queries
// are checked against a behavioural stack with a single minimum register.
// Depends on mts_pkg and the min_tracking_stack_core RTL.
`timescale 1ns / 100ps

module tb_min_tracking_stack_core;
    import mts_pkg::*;

    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_LOWEST  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_HIGHEST = 32'sh7fff_ffff;

    class min_stack_tracker;
        logic signed [ENTRY_W-1:0] entries [STACK_DEPTH];
        int unsigned               fill;
        logic signed [DATA_W-1:0]  minimum;
        t_result                   expected_reports[$];
        int errors, checked, pushes, pops, refused, underflows;

        function new();
            fill = 0;
            minimum = '0;
            errors = 0;
            checked = 0;
            pushes = 0;
            pops = 0;
            refused = 0;
            underflows = 0;
        endfunction

        function void note_op(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
            t_result r;
            longint  v, m, e;
            v = value;
            m = minimum;
            r.popped_value = -1;
            r.status = STATUS_OK;
            if (mode == MODE_PUSH) begin
                if (fill >= STACK_DEPTH) begin
                    r.status = STATUS_OVERFLOW;
                    refused++;
                end else begin
                    if (fill == 0) begin
                        entries[fill] = ENTRY_W'(v);
                        minimum = value;
                    end else if (v < m) begin
                        // below the minimum: store the encoded entry
                        entries[fill] = ENTRY_W'(2 * v - m);
                        minimum = value;
                    end else begin
                        entries[fill] = ENTRY_W'(v);
                    end
                    fill++;
                    pushes++;
                end
            end else if (mode == MODE_POP) begin
                if (fill == 0) begin
                    r.status = STATUS_UNDERFLOW;
                    underflows++;
                end else begin
                    fill--;
                    e = entries[fill];
                    if (e > m) begin
                        r.popped_value = DATA_W'(e);
                    end else begin
                        r.popped_value = minimum;
                        minimum = DATA_W'(2 * m - e);
                    end
                    pops++;
                end
            end
            if (fill != 0) begin
                e = entries[fill - 1];
                m = minimum;
                r.top_value = (e < m) ? minimum : DATA_W'(e);
                r.min_value = minimum;
                r.is_empty = 1'b0;
            end else begin
                r.top_value = -1;
                r.min_value = -1;
                r.is_empty = 1'b1;
            end
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (expected_reports.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            checked++;
            compare_field("popped_value", want.popped_value, got.popped_value);
            compare_field("top_value", want.top_value, got.top_value);
            compare_field("min_value", want.min_value, got.min_value);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("status", want.status, got.status);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic [DATA_W-1:0]          s_tdata = '0;
    logic [MODE_W-1:0]          s_tuser = MODE_NONE;
    logic                       m_tready = 1'b0;
    wire logic                  s_tready;
    wire logic                  m_tvalid;
    wire logic [OUT_TDATA_W-1:0] m_tdata;

    min_stack_tracker tracker = new();

    int burst_left = 1;
    int hold_cycles = 0;

    min_tracking_stack_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // push_value[31:0]
        .i_s_tuser  (s_tuser),   // mode[1:0]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)    // popped, top, min, is_empty, status
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: back-pressure style is redrawn at random as the run goes on; long hold on request
    initial begin : receiver
        int tick;
        int style;
        tick = 0;
        style = 0;
        forever begin
            @(negedge clk);
            tick++;
            if (tick % 64 == 0)
                style = $urandom_range(0, 3);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= (tick % 4 != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result monitor: sample on the edge, check just after it
    initial begin : monitor
        t_result got;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got = m_tdata[$bits(t_result)-1:0];
                #1;
                tracker.check_report(got);
            end
        end
    end

    task automatic send_beat(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= mode;
        do @(posedge clk); while (!s_tready);
        tracker.note_op(mode, value);
        burst_left--;
        if (burst_left <= 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata <= $urandom;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 20);
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        longint t;
        case ($urandom_range(0, 9))
            0: return VAL_LOWEST;
            1: return VAL_HIGHEST;
            2: return tracker.minimum;
            3, 4: return DATA_W'(int'($urandom_range(0, 200)) - 100);
            5: begin
                t = longint'(tracker.minimum) - $urandom_range(1, 50);
                if (t < longint'(VAL_LOWEST))
                    t = VAL_LOWEST;
                return DATA_W'(t);
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic run_mix(int count);
        int done;
        int seg;
        int push_pct;
        int r;
        done = 0;
        while (done < count) begin
            seg = $urandom_range(10, 60);
            push_pct = ($urandom_range(0, 1) == 1) ? 70 : 25;
            repeat (seg) begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    send_beat(MODE_PUSH, pick_value());
                else if (r < 92)
                    send_beat(MODE_POP, $urandom);
                else if (r < 96)
                    send_beat(MODE_NONE, $urandom);
                else
                    send_beat(MODE_SPARE, $urandom);
                done++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-stack cases, equal and encoded minima, extremes
        send_beat(MODE_POP, 32'hffff_ffff);
        send_beat(MODE_NONE, 32'h0);
        send_beat(MODE_SPARE, 32'h5555_aaaa);
        send_beat(MODE_PUSH, 5);
        send_beat(MODE_PUSH, 7);
        send_beat(MODE_PUSH, 5);
        send_beat(MODE_PUSH, 3);
        send_beat(MODE_PUSH, VAL_LOWEST);
        send_beat(MODE_PUSH, VAL_HIGHEST);
        send_beat(MODE_PUSH, VAL_LOWEST);
        send_beat(MODE_NONE, 32'haaaa_5555);
        send_beat(MODE_SPARE, 32'h0);
        repeat (7) send_beat(MODE_POP, $urandom);
        send_beat(MODE_POP, $urandom);
        send_beat(MODE_PUSH, VAL_HIGHEST);
        send_beat(MODE_PUSH, VAL_LOWEST);
        send_beat(MODE_POP, $urandom);
        send_beat(MODE_POP, $urandom);
        wait_all_results();

        // random mix with a long receiver hold part-way
        run_mix(30);
        hold_cycles = 80;
        run_mix(30);
        wait_all_results();

        // fill to the brim, then knock on a full stack
        hold_cycles = 60;
        while (tracker.fill < STACK_DEPTH) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(MODE_NONE, $urandom);
            else
                send_beat(MODE_PUSH, pick_value());
        end
        send_beat(MODE_PUSH, VAL_LOWEST);
        send_beat(MODE_PUSH, VAL_HIGHEST);
        send_beat(MODE_NONE, $urandom);
        send_beat(MODE_PUSH, pick_value());
        wait_all_results();

        // mix near the top of the stack
        hold_cycles = 70;
        run_mix(40);
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        #2;

        $display("Run covered %0d pushes, %0d pops, %0d refused pushes and %0d empty pops,",
                 tracker.pushes, tracker.pops, tracker.refused, tracker.underflows);
        $display("including a fill to full depth; %0d result beats checked.",
                 tracker.checked);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
